@@ rtl/waypoint_heading_follower_core_assert.svh @@
// assertion macros for the waypoint heading follower
// used by files that check their own logic; needs clk and rst_n in scope
`ifndef WAYPOINT_HEADING_FOLLOWER_CORE_ASSERT_SVH
`define WAYPOINT_HEADING_FOLLOWER_CORE_ASSERT_SVH
`ifndef SYNTH
`define WHF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("whf assertion failed");
`define WHF_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("whf forbidden condition seen");
`else
`define WHF_ASSERT(lbl, prop)
`define WHF_NEVER(lbl, expr)
`endif
`endif

@@ rtl/whf_pkg.sv @@
// shared types and constants for the waypoint heading follower
// no dependencies; imported by every module of the block
package whf_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int CORDIC_STEPS = 16;
  localparam int TURN_W       = 32;
  localparam int RADIUS_W     = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int SPEED_W      = 8;
  localparam int IDX_W        = 2;
  localparam int WP_NUM       = 3;

  localparam logic [SPEED_W-1:0] CRUISE_SPEED = 8'd128;
  localparam logic [TURN_W-1:0]  HALF_TURN    = 32'h8000_0000;

  // reset values of the configuration registers
  localparam logic [IDX_W-1:0]    WP_COUNT_RST = 2'd3;
  localparam int                  WP0_X_RST    = 1536;
  localparam int                  WP0_Y_RST    = -128;
  localparam int                  WP1_X_RST    = 1536;
  localparam int                  WP1_Y_RST    = 128;
  localparam int                  WP2_X_RST    = 0;
  localparam int                  WP2_Y_RST    = 0;
  localparam logic [RADIUS_W-1:0] RADIUS_RST   = 32'd16384;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [TURN_W-1:0] TURN_TABLE [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WP_COUNT = 3'd0,
    REG_WP0_X    = 3'd1,
    REG_WP0_Y    = 3'd2,
    REG_WP1_X    = 3'd3,
    REG_WP1_Y    = 3'd4,
    REG_WP2_X    = 3'd5,
    REG_WP2_Y    = 3'd6,
    REG_RADIUS   = 3'd7
  } cfg_reg_t;

endpackage

@@ rtl/whf_cell.sv @@
// one cordic vectoring cell: a single micro-rotation, registered
// depends on whf_pkg for the angle table
module whf_cell #(
  parameter int W    = 19,
  parameter int STEP = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          v_i,
  input  logic signed [W-1:0]           x_i,
  input  logic signed [W-1:0]           y_i,
  input  logic [whf_pkg::TURN_W-1:0]    z_i,
  output logic                          v_o,
  output logic signed [W-1:0]           x_o,
  output logic signed [W-1:0]           y_o,
  output logic [whf_pkg::TURN_W-1:0]    z_o
);
  import whf_pkg::*;

  logic signed [W-1:0]  xs, ys;
  logic signed [W-1:0]  x_nxt, y_nxt;
  logic [TURN_W-1:0]    z_nxt;
  logic                 v_r;
  logic signed [W-1:0]  x_r, y_r;
  logic [TURN_W-1:0]    z_r;

  // arithmetic shift floors
  assign xs = x_i >>> STEP;
  assign ys = y_i >>> STEP;

  always_comb begin
    if (!y_i[W-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + TURN_TABLE[STEP];
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - TURN_TABLE[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign v_o = v_r;
  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

@@ rtl/whf_dist.sv @@
// squared distance against the arrival radius, two register stages
// depends on whf_pkg for the radius width
module whf_dist #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic signed [COORD_BITS:0]     dx,
  input  logic signed [COORD_BITS:0]     dy,
  input  logic [whf_pkg::RADIUS_W-1:0]   radius,
  output logic                           far
);
  import whf_pkg::*;

  localparam int MAG_W = COORD_BITS + 1;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int SUM_W = SQ_W + 1;
  localparam int CMP_W = (SUM_W > RADIUS_W) ? SUM_W : RADIUS_W;

  logic [MAG_W-1:0] mx, my;
  logic [SQ_W-1:0]  sx_nxt, sy_nxt, sx_r, sy_r;
  logic [SUM_W-1:0] sum;
  logic             far_nxt, far_r;

  assign mx = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
  assign my = dy[COORD_BITS] ? (~dy + 1'b1) : dy;

  assign sx_nxt = SQ_W'(mx) * SQ_W'(mx);
  assign sy_nxt = SQ_W'(my) * SQ_W'(my);

  assign sum     = SUM_W'(sx_r) + SUM_W'(sy_r);
  assign far_nxt = CMP_W'(sum) > CMP_W'(radius);

  always_ff @(posedge clk) begin
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    far_r <= far_nxt;
  end

  assign far = far_r;

endmodule

@@ rtl/waypoint_heading_follower_core.sv @@
// top level of the waypoint heading follower: pose in, steering setpoints out
// depends on whf_pkg, whf_cell, whf_dist and the assertion header
`include "waypoint_heading_follower_core_assert.svh"

// Takes one robot pose per beat and steers toward the current waypoint. The
// bearing comes from a row of sixteen cordic cells, one micro-rotation each.
// A pose passes through the offset register, which forms the offset, the
// sixteen cells, the finishing stage, which finishes the angle and the
// arrival test, and the output register. One pose is in work at a time,
// because the waypoint index it may advance is needed by the next one; the
// next pose is taken in the cycle after the result has moved into the output
// register, even if that beat is still waiting downstream, so a new pose is
// never accepted before the last result has left the finishing stage. A
// stalled sink keeps the result in the finishing stage once the output
// register is full, and the input stays blocked until it moves on. On
// arrival speed and rotation are zero and the index moves on unless it is
// at the last waypoint in use. The user must write configuration only while
// idle; the block does not enforce this, and cfg_ready is always high.
module waypoint_heading_follower_core #(
  parameter int COORD_BITS = whf_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = whf_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata, low bit up: pos_x, pos_y, robot_heading, zero fill
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((2*COORD_BITS+ANGLE_BITS+7)/8)*8-1:0] in_tdata,
  // out_tdata, low bit up: speed_setpoint, turn command, heading_error,
  // target_index, zero fill
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [((2*ANGLE_BITS+10+7)/8)*8-1:0] out_tdata,
  // out_tuser: arrived
  output logic                              out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [whf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [whf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import whf_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int A     = ANGLE_BITS;
  localparam int OUT_W = ((2*A+10+7)/8)*8;
  localparam int W     = C + 3;          // cordic datapath, covers gain of the rotation
  localparam int SH    = TURN_W - A;
  localparam logic [TURN_W-1:0] RND = TURN_W'(1) << (SH-1);

  // configuration registers
  logic [IDX_W-1:0]    wp_count_r;
  logic [C-1:0]        wpx_r [WP_NUM];
  logic [C-1:0]        wpy_r [WP_NUM];
  logic [RADIUS_W-1:0] radius_r;

  // control
  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             in_acc, fin_move;

  // offset stage
  logic                 a_v_r;
  logic signed [C:0]    dx_r, dy_r, dx_nxt, dy_nxt;
  logic [A-1:0]         head_r;
  logic [IDX_W-1:0]     tidx_r;
  logic [IDX_W-1:0]     sel;
  logic [C-1:0]         px, py, wx, wy;

  // cell row
  logic                    cv [CORDIC_STEPS+1];
  logic signed [W-1:0]     cx [CORDIC_STEPS+1];
  logic signed [W-1:0]     cy [CORDIC_STEPS+1];
  logic [TURN_W-1:0]       cz [CORDIC_STEPS+1];

  // finishing stage
  logic               far_w, zero_w, adv_w;
  logic [TURN_W-1:0]  zr;
  logic [A-1:0]       ang, err;
  logic [IDX_W-1:0]   count_eff;
  logic               fin_v_r, fin_v_nxt;
  logic [SPEED_W-1:0] fin_speed_r;
  logic [A-1:0]       fin_rot_r, fin_err_r;
  logic               fin_arr_r;
  logic [IDX_W-1:0]   fin_idx_r;

  // output register
  logic               out_v_r, out_v_nxt;
  logic [SPEED_W-1:0] out_speed_r;
  logic [A-1:0]       out_rot_r, out_err_r;
  logic               out_arr_r;
  logic [IDX_W-1:0]   out_idx_r;

  // configuration port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_count_r <= WP_COUNT_RST;
      wpx_r[0]   <= C'(WP0_X_RST);
      wpy_r[0]   <= C'(WP0_Y_RST);
      wpx_r[1]   <= C'(WP1_X_RST);
      wpy_r[1]   <= C'(WP1_Y_RST);
      wpx_r[2]   <= C'(WP2_X_RST);
      wpy_r[2]   <= C'(WP2_Y_RST);
      radius_r   <= RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_WP_COUNT: wp_count_r <= cfg_data[IDX_W-1:0];
        REG_WP0_X:    wpx_r[0]   <= cfg_data[C-1:0];
        REG_WP0_Y:    wpy_r[0]   <= cfg_data[C-1:0];
        REG_WP1_X:    wpx_r[1]   <= cfg_data[C-1:0];
        REG_WP1_Y:    wpy_r[1]   <= cfg_data[C-1:0];
        REG_WP2_X:    wpx_r[2]   <= cfg_data[C-1:0];
        REG_WP2_Y:    wpy_r[2]   <= cfg_data[C-1:0];
        REG_RADIUS:   radius_r   <= cfg_data[RADIUS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input side: one pose in work at a time
  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;

  assign px  = in_tdata[C-1:0];
  assign py  = in_tdata[2*C-1:C];

  // an index of 3 never occurs, but would pick the third waypoint
  assign sel = (idx_r > IDX_W'(2)) ? IDX_W'(2) : idx_r;
  assign wx  = wpx_r[sel];
  assign wy  = wpy_r[sel];

  assign dx_nxt = {wx[C-1], wx} - {px[C-1], px};
  assign dy_nxt = {wy[C-1], wy} - {py[C-1], py};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= in_acc;
    end
  end

  // offset and heading hold until the next pose, the distance unit and the
  // finishing stage read them late
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      head_r <= in_tdata[2*C+A-1:2*C];
      tidx_r <= idx_r;
    end
  end

  // distance test on the held offset, settled before the finishing stage reads it
  whf_dist #(
    .COORD_BITS (C)
  ) u_dist (
    .clk    (clk),
    .dx     (dx_r),
    .dy     (dy_r),
    .radius (radius_r),
    .far    (far_w)
  );

  // left half plane: mirror the vector and start from a half turn
  assign cv[0] = a_v_r;
  assign cx[0] = dx_r[C] ? -W'(dx_r) : W'(dx_r);
  assign cy[0] = dx_r[C] ? -W'(dy_r) : W'(dy_r);
  assign cz[0] = dx_r[C] ? HALF_TURN : '0;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    whf_cell #(
      .W    (W),
      .STEP (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .v_i   (cv[k]),
      .x_i   (cx[k]),
      .y_i   (cy[k]),
      .z_i   (cz[k]),
      .v_o   (cv[k+1]),
      .x_o   (cx[k+1]),
      .y_o   (cy[k+1]),
      .z_o   (cz[k+1])
    );
  end

  // round the turn angle half up to the output width
  assign zero_w    = (dx_r == '0) && (dy_r == '0);
  assign zr        = cz[CORDIC_STEPS] + RND;
  assign ang       = zero_w ? '0 : zr[TURN_W-1:SH];
  assign err       = ang - head_r;
  // a count of zero behaves as one
  assign count_eff = (wp_count_r == '0) ? IDX_W'(1) : wp_count_r;
  assign adv_w     = !far_w && ({1'b0, tidx_r} + 3'd1 < {1'b0, count_eff});

  always_ff @(posedge clk) begin
    if (cv[CORDIC_STEPS]) begin
      fin_speed_r <= far_w ? CRUISE_SPEED : '0;
      fin_rot_r   <= far_w ? ang : '0;
      fin_err_r   <= err;
      fin_arr_r   <= !far_w;
      fin_idx_r   <= tidx_r;
    end
  end

  // result waits in the finishing stage until the output register frees up
  assign fin_move = fin_v_r && (!out_v_r || out_tready);

  always_comb begin
    fin_v_nxt = fin_v_r;
    if (cv[CORDIC_STEPS]) begin
      fin_v_nxt = 1'b1;
    end else if (fin_move) begin
      fin_v_nxt = 1'b0;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (fin_move) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cv[CORDIC_STEPS] && adv_w) begin
      idx_nxt = tidx_r + IDX_W'(1);
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (fin_move) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      idx_r   <= '0;
      fin_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      idx_r   <= idx_nxt;
      fin_v_r <= fin_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      out_speed_r <= fin_speed_r;
      out_rot_r   <= fin_rot_r;
      out_err_r   <= fin_err_r;
      out_arr_r   <= fin_arr_r;
      out_idx_r   <= fin_idx_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'({out_idx_r, out_err_r, out_rot_r, out_speed_r});
  assign out_tuser  = out_arr_r;

  // at most one of the offset stage, the end of the cell row and the finishing stage holds a pose
  `WHF_ASSERT(a_one_in_flight, $onehot0({a_v_r, cv[CORDIC_STEPS], fin_v_r}))
  // the end of the row only fires while a pose is owned
  `WHF_ASSERT(a_row_end_busy, cv[CORDIC_STEPS] |-> busy_r)
  // an accepted pose enters the offset stage next cycle
  `WHF_ASSERT(a_accept_enters, in_acc |=> a_v_r)
  // the waypoint index stops at the third waypoint
  `WHF_NEVER(a_idx_range, idx_r == 2'd3)
  // an arrival beat carries zero speed and zero rotation
  `WHF_ASSERT(a_arrival_zero, (out_v_r && out_arr_r) |-> (out_speed_r == '0 && out_rot_r == '0))

endmodule
